@@ rtl/core/lcd_scanline_mode_sequencer_defines.svh @@
// Assertion macros for the scanline sequencer RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef LCD_SCANLINE_MODE_SEQUENCER_DEFINES_SVH
`define LCD_SCANLINE_MODE_SEQUENCER_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define LSMS_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("lcd_sms: assertion failed");

// Condition that must never hold outside reset.
`define LSMS_NEVER(name, cond) \
	`LSMS_ASSERT(name, !(cond))

`endif

@@ rtl/core/lcd_sms_pkg.sv @@
// Shared types and constants of the LCD scanline mode sequencer.
// Used by the front, queue and back modules; depends on nothing.
package lcd_sms_pkg;

	localparam logic [7:0] LINES_PER_FRAME = 8'd154;
	localparam logic [7:0] VISIBLE_LINES   = 8'd144;
	localparam logic [7:0] LINE_RESET      = 8'd153;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register indexes
	localparam logic REG_CARTRIDGE_LOADED = 1'b0;
	localparam logic REG_FRAME_SKIP       = 1'b1;

	// Segment length constants
	localparam logic [8:0] CYC_LINE     = 9'd456;
	localparam logic [8:0] CYC_OAM      = 9'd80;
	localparam logic [8:0] CYC_XFER     = 9'd169;
	localparam logic [8:0] CYC_HBLANK   = 9'd207;
	localparam logic [8:0] CYC_VB_START = 9'd72;
	localparam logic [8:0] CYC_REST     = CYC_LINE - CYC_OAM;

	// STAT mode codes
	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_OAM    = 2'd2;
	localparam logic [1:0] MODE_XFER   = 2'd3;

	// Frame actions
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_PRESENT = 2'd1;
	localparam logic [1:0] ACT_BLANK   = 2'd2;

	// DMA source regions
	localparam logic [2:0] RGN_ROM0  = 3'd0;
	localparam logic [2:0] RGN_ROMX  = 3'd1;
	localparam logic [2:0] RGN_SRAM  = 3'd2;
	localparam logic [2:0] RGN_WRAM0 = 3'd3;
	localparam logic [2:0] RGN_WRAMX = 3'd4;
	localparam logic [2:0] RGN_NONE  = 3'd5;

	// Line job kinds
	localparam logic [2:0] JOB_OFF      = 3'd0;
	localparam logic [2:0] JOB_VB_START = 3'd1;
	localparam logic [2:0] JOB_LAST     = 3'd2;
	localparam logic [2:0] JOB_VBLANK   = 3'd3;
	localparam logic [2:0] JOB_VISIBLE  = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  ly;
		logic        coin;
		logic [1:0]  irq0;
		logic [1:0]  action;
		logic        vb_stat_irq;
		logic        hb_stat_irq;
		logic        render;
		logic        dma_valid;
		logic [15:0] dma_src;
		logic [12:0] vram_offset;
		logic [2:0]  dma_region;
	} job_t;

	function automatic logic [2:0] region_of(input logic [15:0] a);
		logic [2:0] r;
		if (a inside {[16'h0000:16'h3fff]})
			r = RGN_ROM0;
		else if (a inside {[16'h4000:16'h7fff]})
			r = RGN_ROMX;
		else if (a inside {[16'ha000:16'hbfff]})
			r = RGN_SRAM;
		else if (a inside {[16'hc000:16'hcfff]})
			r = RGN_WRAM0;
		else if (a inside {[16'hd000:16'hdfff]})
			r = RGN_WRAMX;
		else
			r = RGN_NONE;
		return r;
	endfunction

	function automatic logic [1:0] last_seg(input logic [2:0] kind);
		logic [1:0] n;
		case (kind)
			JOB_VISIBLE:  n = 2'd2;
			JOB_VB_START: n = 2'd1;
			JOB_LAST:     n = 2'd1;
			default:      n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/core/lcd_sms_front.sv @@
// Front end: holds the configuration and line/DMA state, classifies each tick
// into a line job. Depends on lcd_sms_pkg.
module lcd_sms_front import lcd_sms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_wdata,
	input  logic        accept,
	input  logic        lcd_on,
	input  logic [3:0]  stat_enables,
	input  logic [7:0]  lyc,
	input  logic        render_masked,
	input  logic        hdma_arm,
	input  logic [15:0] hdma_src_start,
	input  logic [15:0] hdma_dest_start,
	input  logic [7:0]  hdma_blocks,
	output logic        job_push,
	output job_t        job
);

	logic        cart_q;
	logic [3:0]  skip_q;
	logic [7:0]  lc_q;
	logic [3:0]  fsp_q;
	logic [7:0]  lwo_q;
	logic        dma_active_q;
	logic        dma_first_q;
	logic [15:0] dma_src_q;
	logic [15:0] dma_dst_q;
	logic [7:0]  dma_left_q;
	logic [2:0]  dma_region_q;

	logic        a_active, a_first;
	logic [15:0] a_src, a_dest;
	logic [7:0]  a_left;
	logic [7:0]  lwo_inc;
	logic        off_wrap;
	logic [8:0]  sum9, ly9;
	logic [7:0]  ly;
	logic        tick_due, tick_now;
	logic [3:0]  fsp_next;
	logic        visible, dma_step;
	logic [2:0]  region_now;
	logic [7:0]  left_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_q <= 1'b0;
			skip_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CARTRIDGE_LOADED: cart_q <= cfg_wdata[0];
				REG_FRAME_SKIP:       skip_q <= cfg_wdata;
				default:              ;
			endcase
		end
	end

	// An arm request takes effect before the line itself is processed.
	assign a_active = hdma_arm ? 1'b1 : dma_active_q;
	assign a_first  = hdma_arm ? 1'b1 : dma_first_q;
	assign a_src    = hdma_arm ? hdma_src_start : dma_src_q;
	assign a_dest   = hdma_arm ? hdma_dest_start : dma_dst_q;
	assign a_left   = hdma_arm ? hdma_blocks : dma_left_q;

	assign lwo_inc  = lwo_q + 8'd1;
	assign off_wrap = lwo_inc >= LINES_PER_FRAME;

	// The counter never exceeds 255, so one subtraction finishes the wrap.
	assign sum9 = {1'b0, lc_q} + 9'd1;
	assign ly9  = (sum9 >= {1'b0, LINES_PER_FRAME}) ? sum9 - {1'b0, LINES_PER_FRAME} : sum9;
	assign ly   = ly9[7:0];

	assign tick_due = lcd_on ? (ly == 8'd0) : off_wrap;
	assign tick_now = fsp_q >= skip_q;
	assign fsp_next = !tick_due ? fsp_q : (tick_now ? 4'd0 : fsp_q + 4'd1);

	assign visible    = ly < VISIBLE_LINES;
	assign dma_step   = lcd_on && visible && a_active;
	assign region_now = a_first ? region_of(a_src) : dma_region_q;
	assign left_dec   = a_left - 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q         <= LINE_RESET;
			fsp_q        <= '0;
			lwo_q        <= '0;
			dma_active_q <= 1'b0;
			dma_first_q  <= 1'b0;
			dma_src_q    <= '0;
			dma_dst_q    <= '0;
			dma_left_q   <= '0;
			dma_region_q <= '0;
		end else if (accept && cart_q) begin
			fsp_q <= fsp_next;
			if (lcd_on) begin
				lc_q <= ly;
			end else begin
				lc_q  <= 8'd0;
				lwo_q <= off_wrap ? 8'd0 : lwo_inc;
			end
			if (dma_step) begin
				dma_active_q <= left_dec != 8'd0;
				dma_first_q  <= 1'b0;
				dma_src_q    <= (a_src + 16'd16) & 16'hfff0;
				dma_dst_q    <= (a_dest + 16'd16) & 16'hfff0;
				dma_left_q   <= left_dec;
				dma_region_q <= region_now;
			end else begin
				dma_active_q <= a_active;
				dma_first_q  <= a_first;
				dma_src_q    <= a_src;
				dma_dst_q    <= a_dest;
				dma_left_q   <= a_left;
			end
		end
	end

	assign job_push = accept && cart_q;

	always_comb begin
		job = '0;
		if (!lcd_on) begin
			job.kind   = JOB_OFF;
			job.action = (off_wrap && tick_now) ? ACT_BLANK : ACT_NONE;
		end else begin
			job.ly      = ly;
			job.coin    = lyc == ly;
			job.irq0[1] = (job.coin && stat_enables[3]) || (visible && stat_enables[2]);
			job.action  = ((ly == 8'd0) && tick_now) ? ACT_PRESENT : ACT_NONE;
			job.vb_stat_irq = stat_enables[1];
			job.hb_stat_irq = stat_enables[0];
			if (visible) begin
				job.kind        = JOB_VISIBLE;
				job.render      = (fsp_next >= skip_q) && !render_masked;
				job.dma_valid   = dma_step;
				job.dma_src     = dma_step ? a_src : 16'd0;
				job.vram_offset = dma_step ? (a_dest[12:0] & 13'h1ff0) : 13'd0;
				job.dma_region  = dma_step ? region_now : 3'd0;
			end else if (ly == VISIBLE_LINES) begin
				job.kind = JOB_VB_START;
			end else if (ly == LINES_PER_FRAME - 8'd1) begin
				job.kind = JOB_LAST;
			end else begin
				job.kind = JOB_VBLANK;
			end
		end
	end

endmodule

@@ rtl/core/lcd_sms_queue.sv @@
// Short job queue between the front and back ends, held in flip-flops.
// Depends on lcd_sms_pkg.
module lcd_sms_queue import lcd_sms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic q_empty,
	output logic q_full
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign q_empty = cnt_q == '0;
	assign q_full  = cnt_q == QCNT_W'(QDEPTH);
	assign do_push = push && !q_full;
	assign do_pop  = pop && !q_empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

@@ rtl/core/lcd_sms_back.sv @@
// Back end: loads a line job's segments into the result register, one per
// cycle while it is popped. Depends on lcd_sms_pkg and the assertion macros.
`include "lcd_scanline_mode_sequencer_defines.svh"
module lcd_sms_back import lcd_sms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        head,
	input  logic        q_empty,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  line_number,
	output logic [2:0]  stat_low,
	output logic [8:0]  cycle_count,
	output logic [1:0]  irq_mask,
	output logic        render_line,
	output logic [1:0]  frame_action,
	output logic        dma_valid,
	output logic [15:0] dma_src,
	output logic [12:0] vram_offset,
	output logic [2:0]  dma_region,
	output logic        last_segment
);

	logic        out_valid_q;
	logic [1:0]  seg_q;
	logic [7:0]  line_q;
	logic [2:0]  stat_q;
	logic [8:0]  cyc_q;
	logic [1:0]  irq_q;
	logic        render_q;
	logic [1:0]  action_q;
	logic        dv_q;
	logic [15:0] src_q;
	logic [12:0] dest_q;
	logic [2:0]  region_q;
	logic        last_q;

	logic        out_load, is_last;
	logic [7:0]  n_line;
	logic [2:0]  n_stat;
	logic [8:0]  n_cyc;
	logic [1:0]  n_irq;
	logic        n_render;
	logic [1:0]  n_action;
	logic        n_dv;
	logic [15:0] n_src;
	logic [12:0] n_dest;
	logic [2:0]  n_region;

	assign is_last  = seg_q == last_seg(head.kind);
	assign out_load = !q_empty && (!out_valid_q || pop);
	assign q_pop    = out_load && is_last;

	always_comb begin
		n_line   = head.ly;
		n_stat   = {head.coin, MODE_VBLANK};
		n_cyc    = CYC_LINE;
		n_irq    = head.irq0;
		n_render = 1'b0;
		n_action = (seg_q == 2'd0) ? head.action : ACT_NONE;
		n_dv     = 1'b0;
		n_src    = '0;
		n_dest   = '0;
		n_region = '0;
		case (head.kind)
			JOB_OFF: begin
				n_line = 8'd0;
				n_stat = 3'd0;
				n_irq  = 2'd0;
			end
			JOB_VB_START: begin
				if (seg_q == 2'd0) begin
					n_cyc = CYC_VB_START;
				end else begin
					n_cyc = CYC_REST;
					n_irq = {head.vb_stat_irq, 1'b1};
				end
			end
			JOB_LAST: begin
				if (seg_q == 2'd0) begin
					n_cyc = CYC_OAM;
				end else begin
					// The closing segment of the frame already reports line zero.
					n_line = 8'd0;
					n_cyc  = CYC_REST;
					n_irq  = 2'd0;
				end
			end
			JOB_VISIBLE: begin
				case (seg_q)
					2'd0: begin
						n_stat = {head.coin, MODE_OAM};
						n_cyc  = CYC_OAM;
					end
					2'd1: begin
						n_stat = {head.coin, MODE_XFER};
						n_cyc  = CYC_XFER;
						n_irq  = 2'd0;
					end
					default: begin
						n_stat   = {head.coin, MODE_HBLANK};
						n_cyc    = CYC_HBLANK;
						n_irq    = {head.hb_stat_irq && !head.dma_valid, 1'b0};
						n_render = head.render;
						n_dv     = head.dma_valid;
						n_src    = head.dma_src;
						n_dest   = head.vram_offset;
						n_region = head.dma_region;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			seg_q       <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (out_load)
				seg_q <= is_last ? 2'd0 : seg_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			line_q   <= n_line;
			stat_q   <= n_stat;
			cyc_q    <= n_cyc;
			irq_q    <= n_irq;
			render_q <= n_render;
			action_q <= n_action;
			dv_q     <= n_dv;
			src_q    <= n_src;
			dest_q   <= n_dest;
			region_q <= n_region;
			last_q   <= is_last;
		end
	end

	assign empty        = !out_valid_q;
	assign line_number  = line_q;
	assign stat_low     = stat_q;
	assign cycle_count  = cyc_q;
	assign irq_mask     = irq_q;
	assign render_line  = render_q;
	assign frame_action = action_q;
	assign dma_valid    = dv_q;
	assign dma_src      = src_q;
	assign vram_offset  = dest_q;
	assign dma_region   = region_q;
	assign last_segment = last_q;

	`LSMS_NEVER(a_seg_range, seg_q == 2'd3)
	`LSMS_ASSERT(a_dma_hb, (out_valid_q && dv_q) |-> (last_q && stat_q[1:0] == MODE_HBLANK && irq_q == '0))
	`LSMS_ASSERT(a_seg_restart, (out_load && is_last) |=> (seg_q == 2'd0))
	`LSMS_ASSERT(a_job_pop, q_pop |-> (seg_q == last_seg(head.kind) && !q_empty))

endmodule

@@ rtl/core/lcd_scanline_mode_sequencer.sv @@
// With a cartridge loaded, an accepted tick's job is first written into the job queue; its first
// segment is then loaded into the result register, one segment per cycle while it is popped. A tick has
// 1 to 3 segments (visible lines 3, VBlank start and last line 2, others 1), set by the segment expander.
// A four-entry job queue lets ticks be accepted while earlier segments are still pending.
// Reset (arst_n low) clears the configuration, the queue and the result valid flag and sets
// the line counter to 153; no clearing pass is needed.
module lcd_scanline_mode_sequencer import lcd_sms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic        lcd_on,
	input  logic [3:0]  stat_enables,
	input  logic [7:0]  lyc,
	input  logic        render_masked,
	input  logic        hdma_arm,
	input  logic [15:0] hdma_src_start,
	input  logic [15:0] hdma_dest_start,
	input  logic [7:0]  hdma_blocks,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  line_number,
	output logic [2:0]  stat_low,
	output logic [8:0]  cycle_count,
	output logic [1:0]  irq_mask,
	output logic        render_line,
	output logic [1:0]  frame_action,
	output logic        dma_valid,
	output logic [15:0] dma_src,
	output logic [12:0] vram_offset,
	output logic [2:0]  dma_region,
	output logic        last_segment
);

	logic accept, job_push, q_pop, q_empty, q_full;
	job_t job, head;

	assign full   = q_full;
	assign accept = push && !q_full;

	lcd_sms_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.accept          (accept),
		.lcd_on          (lcd_on),
		.stat_enables    (stat_enables),
		.lyc             (lyc),
		.render_masked   (render_masked),
		.hdma_arm        (hdma_arm),
		.hdma_src_start  (hdma_src_start),
		.hdma_dest_start (hdma_dest_start),
		.hdma_blocks     (hdma_blocks),
		.job_push        (job_push),
		.job             (job)
	);

	lcd_sms_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job),
		.pop      (q_pop),
		.head     (head),
		.q_empty  (q_empty),
		.q_full   (q_full)
	);

	lcd_sms_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.line_number  (line_number),
		.stat_low     (stat_low),
		.cycle_count  (cycle_count),
		.irq_mask     (irq_mask),
		.render_line  (render_line),
		.frame_action (frame_action),
		.dma_valid    (dma_valid),
		.dma_src      (dma_src),
		.vram_offset  (vram_offset),
		.dma_region   (dma_region),
		.last_segment (last_segment)
	);

endmodule
